[rtl/yt_pkg.sv]
// Shared types and constants of the Young tableau priority queue.
`default_nettype none

package yt_pkg;

	localparam int ROWS  = 8;
	localparam int COLS  = 8;
	localparam int CELLS = ROWS * COLS;
	localparam int KW    = 32;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

	typedef logic signed [KW-1:0] key_t;
	typedef logic [AW-1:0]        addr_t;
	typedef logic [RW-1:0]        row_t;
	typedef logic [CW-1:0]        col_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MIN,
		S_N1,
		S_N2,
		S_SCMP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		key_t  wdata;
		addr_t raddr;
	} ram_req_t;

	typedef struct packed {
		key_t       min_value;
		logic       found;
		logic [1:0] status;
	} result_t;

endpackage

`default_nettype wire

[rtl/yt_if.sv]
// Command and response channel interfaces of the tableau queue.
`default_nettype none

interface yt_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [31:0] key;

	modport source (output valid, output command, output key, input ready);
	modport sink (input valid, input command, input key, output ready);
endinterface

interface yt_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] min_value;
	logic               found;
	logic [1:0]         status;

	modport source (output valid, output min_value, output found, output status, input ready);
	modport sink (input valid, input min_value, input found, input status, output ready);
endinterface

`default_nettype wire

[rtl/young_tableau_priority_queue_top.sv]
// Top level of the Young tableau priority queue.
`default_nettype none

// Channel  Role   Word                      Taken when
// cmd      sink   command[1:0], key[31:0]   cmd.valid && cmd.ready
// rsp      source min_value, found, status  rsp.valid && rsp.ready
//
// Insert and delete visit up to ROWS+COLS-1 cells, each visit reading two
// neighbors through the single read port of the key store; search walks
// one cell per cycle.
// Reset empties the tableau at once: occupancy lives in flip-flops, no sweep.
// cmd.ready is high only between commands; a finished response moves to the
// output register, so a stalled rsp channel holds at most one extra response.

module young_tableau_priority_queue_top import yt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	yt_cmd_if.sink   cmd,
	yt_rsp_if.source rsp
);

	ram_req_t ram_req;
	key_t     ram_rdata;
	logic     res_valid;
	result_t  res_data;
	logic     res_take;

	// sequencer owns occupancy bits and drives every key store access
	yt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_take  (res_take)
	);

	// keys, registered read data; walk steps never read the cell just written
	yt_key_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// hold the response word until the consumer takes it
	yt_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_take  (res_take),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[rtl/yt_key_ram.sv]
// Key store: one write port, one read port, registered read data.
`default_nettype none

module yt_key_ram import yt_pkg::*; (
	input  wire logic     clk,
	input  wire ram_req_t req,
	output key_t          rdata
);

	key_t mem [CELLS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

[rtl/yt_out_reg.sv]
// Response register between the sequencer and the response channel.
`default_nettype none

module yt_out_reg import yt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_valid,
	input  wire result_t res_data,
	output logic         res_take,
	yt_rsp_if.source     rsp
);

	logic    valid_q;
	result_t data_q;

	assign res_take = res_valid && (!valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_take) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			data_q <= res_data;
		end
	end

	assign rsp.valid     = valid_q;
	assign rsp.min_value = data_q.min_value;
	assign rsp.found     = data_q.found;
	assign rsp.status    = data_q.status;

endmodule

`default_nettype wire

[rtl/yt_ctrl.sv]
// Sequencer: bubble, sift and staircase walks over the key store, plus occupancy bits.
`default_nettype none

module yt_ctrl import yt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	yt_cmd_if.sink    cmd,
	output ram_req_t  ram_req,
	input  wire key_t ram_rdata,
	output logic      res_valid,
	output result_t   res_data,
	input  wire logic res_take
);

	function automatic addr_t cell_addr(input row_t r, input col_t c);
		return addr_t'(int'(r) * COLS + int'(c));
	endfunction

	// x ranks above y; an empty cell is plus infinity
	function automatic logic cell_gt(input logic fx, input key_t kx,
		input logic fy, input key_t ky);
		if (!fx) begin
			return fy;
		end
		if (!fy) begin
			return 1'b0;
		end
		return ky < kx;
	endfunction

	state_t           state_q, state_d;
	cmd_t             op_q, op_d;
	row_t             row_q, row_d;
	col_t             col_q, col_d;
	key_t             key_q, key_d;
	key_t             n1_key_q, n1_key_d;
	result_t          result_q, result_d;
	logic [CELLS-1:0] full_q, full_d;

	logic  ins;
	addr_t cur_addr, n1_addr, n2_addr, nn1_addr;
	logic  n1_ok, n2_ok, n1_full, n2_full, cur_full;
	logic  go1, go2, up_gt, dn_sel, b_full;
	key_t  b_key;
	row_t  new_row;
	col_t  new_col;

	assign ins      = (op_q == CMD_INSERT);
	assign cur_addr = cell_addr(row_q, col_q);
	assign n1_addr  = ins ? cell_addr(row_q - RW'(1), col_q) : cell_addr(row_q + RW'(1), col_q);
	assign n2_addr  = ins ? cell_addr(row_q, col_q - CW'(1)) : cell_addr(row_q, col_q + CW'(1));
	assign n1_ok    = ins ? (row_q != '0) : (row_q != RW'(ROWS - 1));
	assign n2_ok    = ins ? (col_q != '0) : (col_q != CW'(COLS - 1));
	assign n1_full  = full_q[n1_addr];
	assign n2_full  = full_q[n2_addr];
	assign cur_full = full_q[cur_addr];

	// insert moves a full key against the larger neighbor, delete a hole
	// against the smaller one; ties keep the vertical move
	assign up_gt  = n1_ok && cell_gt(n1_full, n1_key_q, 1'b1, key_q);
	assign dn_sel = n1_ok && n1_full;
	assign go1    = ins ? up_gt : dn_sel;
	assign b_full = ins ? (up_gt ? n1_full : 1'b1) : (dn_sel ? n1_full : 1'b0);
	assign b_key  = (ins && !up_gt) ? key_q : n1_key_q;
	assign go2    = n2_ok && (ins ? cell_gt(n2_full, ram_rdata, b_full, b_key)
	                              : cell_gt(b_full, b_key, n2_full, ram_rdata));

	always_comb begin
		new_row = row_q;
		new_col = col_q;
		if (go2) begin
			new_col = ins ? col_q - CW'(1) : col_q + CW'(1);
		end else if (go1) begin
			new_row = ins ? row_q - RW'(1) : row_q + RW'(1);
		end
	end

	assign nn1_addr = ins ? cell_addr(new_row - RW'(1), new_col)
	                      : cell_addr(new_row + RW'(1), new_col);

	assign cmd.ready = (state_q == S_IDLE);

	always_comb begin
		state_d         = state_q;
		op_d            = op_q;
		row_d           = row_q;
		col_d           = col_q;
		key_d           = key_q;
		n1_key_d        = n1_key_q;
		result_d        = result_q;
		full_d          = full_q;
		ram_req.we      = 1'b0;
		ram_req.waddr   = cur_addr;
		ram_req.wdata   = key_q;
		ram_req.raddr   = n1_addr;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					result_d = '{min_value: '0, found: 1'b0, status: ST_OK};
					key_d    = cmd.key;
					unique case (cmd.command)
						CMD_INSERT: begin
							if (full_q[CELLS-1]) begin
								result_d.status = ST_OVERFLOW;
								state_d         = S_FIN;
							end else begin
								op_d          = CMD_INSERT;
								row_d         = RW'(ROWS - 1);
								col_d         = CW'(COLS - 1);
								ram_req.raddr = cell_addr(RW'(ROWS - 1) - RW'(1), CW'(COLS - 1));
								state_d       = S_N1;
							end
						end
						CMD_DELETE: begin
							if (!full_q[0]) begin
								result_d.status = ST_UNDERFLOW;
								state_d         = S_FIN;
							end else begin
								op_d          = CMD_DELETE;
								row_d         = '0;
								col_d         = '0;
								ram_req.raddr = cell_addr('0, '0);
								state_d       = S_MIN;
							end
						end
						CMD_SEARCH: begin
							op_d          = CMD_SEARCH;
							row_d         = RW'(ROWS - 1);
							col_d         = '0;
							ram_req.raddr = cell_addr(RW'(ROWS - 1), '0);
							state_d       = S_SCMP;
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_MIN: begin
				// capture the minimum, then fetch the lower neighbor
				result_d.min_value = ram_rdata;
				state_d            = S_N1;
			end
			S_N1: begin
				n1_key_d      = ram_rdata;
				ram_req.raddr = n2_addr;
				state_d       = S_N2;
			end
			S_N2: begin
				if (go1 || go2) begin
					// pull the chosen neighbor into the current cell and advance
					ram_req.we       = 1'b1;
					ram_req.wdata    = go2 ? ram_rdata : n1_key_q;
					full_d[cur_addr] = go2 ? n2_full : n1_full;
					row_d            = new_row;
					col_d            = new_col;
					ram_req.raddr    = nn1_addr;
					state_d          = S_N1;
				end else begin
					if (ins) begin
						ram_req.we = 1'b1;
					end
					full_d[cur_addr] = ins;
					state_d          = S_FIN;
				end
			end
			S_SCMP: begin
				if (cur_full && ram_rdata == key_q) begin
					result_d.found = 1'b1;
					state_d        = S_FIN;
				end else if (cur_full && ram_rdata < key_q) begin
					if (col_q == CW'(COLS - 1)) begin
						state_d = S_FIN;
					end else begin
						col_d         = col_q + CW'(1);
						ram_req.raddr = cell_addr(row_q, col_q + CW'(1));
					end
				end else begin
					if (row_q == '0) begin
						state_d = S_FIN;
					end else begin
						row_d         = row_q - RW'(1);
						ram_req.raddr = cell_addr(row_q - RW'(1), col_q);
					end
				end
			end
			S_FIN: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			full_q  <= '0;
		end else begin
			state_q <= state_d;
			full_q  <= full_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		row_q    <= row_d;
		col_q    <= col_d;
		key_q    <= key_d;
		n1_key_q <= n1_key_d;
		result_q <= result_d;
	end

	assign res_valid = (state_q == S_FIN);
	assign res_data  = result_q;

	a_write_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> state_q == S_N2)
		else $error("key store written outside a walk step");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_N1 || state_q == S_N2 || state_q == S_SCMP)
		|-> (int'(row_q) < ROWS && int'(col_q) < COLS))
		else $error("walk position left the tableau");

	a_full_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_N2 |=> full_q == $past(full_q))
		else $error("occupancy changed outside a walk step");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !res_take) |=> (state_q == S_FIN && $stable(result_q)))
		else $error("pending result dropped or changed");

endmodule

`default_nettype wire
